>>> design/assert_macros.svh
// Assertion macros shared by the scheduler modules.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define STS_ASSERT_NOW(lbl, pre, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (con)) \
		else $error(msg);
`define STS_ASSERT_NEXT(lbl, pre, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (con)) \
		else $error(msg);
`else
`define STS_ASSERT_NOW(lbl, pre, con, msg)
`define STS_ASSERT_NEXT(lbl, pre, con, msg)
`endif
`endif

>>> design/sts_pkg.sv
// Shared types, constants and the slot ID table of the telemetry slot scheduler.
// No dependencies.
`timescale 1ns / 1ps
package sts_pkg;

	localparam int FRAME_BYTES     = 25;
	localparam int SLOTS_PER_GROUP = 8;
	localparam int TOTAL_SLOTS     = 32;

	localparam int SLOT_IDX_W = $clog2(TOTAL_SLOTS);
	localparam int SLOT_CNT_W = $clog2(SLOTS_PER_GROUP);
	localparam int GROUP_W    = SLOT_IDX_W - SLOT_CNT_W;
	localparam int BCNT_W     = 5;
	localparam int TIMER_W    = 16;
	localparam int VALUE_W    = 16;

	localparam logic [7:0] HEADER_BYTE = 8'h0F;
	localparam logic [7:0] FOOTER_SBUS = 8'h00;
	localparam logic [3:0] FOOTER_SBUS2_LOW = 4'h4;
	localparam logic [BCNT_W-1:0] BYTE_COUNT_MAX = {BCNT_W{1'b1}};
	localparam logic [BCNT_W-1:0] FRAME_LEN = BCNT_W'(FRAME_BYTES);
	localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
	localparam logic [SLOT_CNT_W-1:0] LAST_SLOT = SLOT_CNT_W'(SLOTS_PER_GROUP - 1);

	typedef enum logic [1:0] {
		FUNC_RX_BYTE  = 2'd0,
		FUNC_TICK     = 2'd1,
		FUNC_VALUE_WR = 2'd2
	} sts_func_t;

	typedef enum logic [1:0] {
		REG_SLOT_ZERO_DELAY  = 2'd0,
		REG_INTER_SLOT_DELAY = 2'd1,
		REG_FRAME_GAP        = 2'd2,
		REG_PRESENT_MASK     = 2'd3
	} sts_reg_t;

	typedef enum logic [1:0] {
		BYTE_ID   = 2'd0,
		BYTE_LOW  = 2'd1,
		BYTE_HIGH = 2'd2
	} sts_byte_sel_t;

	typedef struct packed {
		logic        en;
		logic [1:0]  index;
		logic [31:0] data;
	} sts_cfg_wr_t;

	typedef struct packed {
		logic                  en;
		logic [SLOT_IDX_W-1:0] addr;
		logic [VALUE_W-1:0]    data;
	} sts_ram_wr_t;

	typedef struct packed {
		logic                  en;
		logic [SLOT_IDX_W-1:0] addr;
	} sts_ram_rd_t;

	typedef struct packed {
		logic       fire;
		logic [7:0] slot_id;
	} sts_job_t;

	typedef struct packed {
		logic job_wait;
		logic byte_hold;
	} sts_emit_status_t;

	localparam logic [7:0] SLOT_ID_TABLE [TOTAL_SLOTS] = '{
		8'h03, 8'h83, 8'h43, 8'hC3, 8'h23, 8'hA3, 8'h63, 8'hE3,
		8'h13, 8'h93, 8'h53, 8'hD3, 8'h33, 8'hB3, 8'h73, 8'hF3,
		8'h0B, 8'h8B, 8'h4B, 8'hCB, 8'h2B, 8'hAB, 8'h6B, 8'hEB,
		8'h1B, 8'h9B, 8'h5B, 8'hDB, 8'h3B, 8'hBB, 8'h7B, 8'hFB
	};

endpackage

>>> design/sbus2_telemetry_slot_scheduler.sv
// Top level of the telemetry slot scheduler: ports, input decode and block wiring.
// Depends on sts_pkg, sts_frame_sched, sts_value_ram, sts_tx_emitter, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
// The slave stream carries one command per transfer; the command code on s_axis_tuser
// selects a received bus byte, a one microsecond tick, or a sensor value write. The
// frame scheduler keeps the frame and burst state in registers and the 32 sensor
// values sit in a one-port-write, one-port-read memory with a registered read.
// A tick that fires a present slot reads its value from the memory; in the next cycle
// the emitter loads the slot ID and value and sends three bytes on the master stream,
// ID, value low byte and value high byte, with tlast on the high byte. The first output
// byte follows the memory read and job registers, then the emitter's byte registers.
// Bytes, value writes and ticks that fire nothing are taken one per cycle while no
// fired slot holds the input. A tick that fires a slot occupies the block for the
// memory read and the three output bytes; the next command is taken in the cycle
// the high byte transfers. When the receiver stalls, the output byte holds and
// s_axis_tready drops until the last byte of the current slot has been taken.
// The configuration channel is always ready and takes one register write per transfer.
// Reset restores the register defaults, clears the frame and burst state, and marks
// every stored value as zero through per-entry valid bits, with no clearing pass.
module sbus2_telemetry_slot_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] rx_byte, [12:8] slot_index, [28:13] sensor_value, [31:29] zero
	input  logic [31:0] s_axis_tdata,
	// [1:0] func
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] tx_byte
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import sts_pkg::*;

	sts_cfg_wr_t      cfg_wr;
	sts_ram_wr_t      ram_wr;
	sts_ram_rd_t      ram_rd;
	sts_job_t         job;
	sts_emit_status_t emit_status;
	logic [VALUE_W-1:0] rd_data;
	logic             in_accept;

	// Configuration writes land directly in the scheduler registers.
	assign cfg_ready    = 1'b1;
	assign cfg_wr.en    = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	// Hold off new commands only while a fired slot has bytes still to send.
	assign s_axis_tready = !emit_status.job_wait && !emit_status.byte_hold;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	sts_frame_sched u_sched (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_wr),
		.accept       (in_accept),
		.func         (s_axis_tuser),
		.rx_byte      (s_axis_tdata[7:0]),
		.slot_index   (s_axis_tdata[12:8]),
		.sensor_value (s_axis_tdata[28:13]),
		.ram_wr       (ram_wr),
		.ram_rd       (ram_rd),
		.job          (job)
	);

	sts_value_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (ram_wr),
		.rd      (ram_rd),
		.rd_data (rd_data)
	);

	sts_tx_emitter u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.rd_data   (rd_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.status    (emit_status)
	);

	// A firing tick must close the input until its bytes have drained.
	`STS_ASSERT_NEXT(a_fire_blocks_input, in_accept && job.fire, !s_axis_tready, "input open after a fire")

endmodule

>>> design/sts_value_ram.sv
// Sensor value store: one write port, one registered read port, per-entry valid bits.
// Depends on sts_pkg.
`timescale 1ns / 1ps
module sts_value_ram (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sts_pkg::sts_ram_wr_t              wr,
	input  sts_pkg::sts_ram_rd_t              rd,
	output logic [sts_pkg::VALUE_W-1:0]       rd_data
);
	import sts_pkg::*;

	logic [VALUE_W-1:0]     mem [TOTAL_SLOTS];
	logic [TOTAL_SLOTS-1:0] valid_q;
	logic [VALUE_W-1:0]     data_q;
	logic                   hit_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			data_q <= mem[rd.addr];
		end
	end

	// An entry never written reads as zero, matching the cleared reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				hit_q <= valid_q[rd.addr];
			end
		end
	end

	assign rd_data = hit_q ? data_q : '0;

endmodule

>>> design/sts_frame_sched.sv
// Frame detection by idle time, slot group selection and the slot firing schedule.
// Depends on sts_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sts_frame_sched (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sts_pkg::sts_cfg_wr_t              cfg,
	input  logic                              accept,
	input  logic [1:0]                        func,
	input  logic [7:0]                        rx_byte,
	input  logic [sts_pkg::SLOT_IDX_W-1:0]    slot_index,
	input  logic [sts_pkg::VALUE_W-1:0]       sensor_value,
	output sts_pkg::sts_ram_wr_t              ram_wr,
	output sts_pkg::sts_ram_rd_t              ram_rd,
	output sts_pkg::sts_job_t                 job
);
	import sts_pkg::*;

	logic [TIMER_W-1:0]    zero_delay_q;
	logic [TIMER_W-1:0]    inter_delay_q;
	logic [TIMER_W-1:0]    frame_gap_q;
	logic [TOTAL_SLOTS-1:0] mask_q;

	logic [GROUP_W-1:0]    group_q;
	logic                  mute_q;
	logic [BCNT_W-1:0]     byte_count_q;
	logic                  header_ok_q;
	logic [7:0]            footer_q;
	logic [TIMER_W-1:0]    idle_q;
	logic                  burst_q;
	logic [SLOT_CNT_W-1:0] slot_cnt_q;
	logic [TIMER_W-1:0]    slot_timer_q;

	logic                  is_tick;
	logic                  is_byte;
	logic                  frame_open;
	logic [TIMER_W-1:0]    idle_inc;
	logic                  close;
	logic                  frame_ok;
	logic                  footer_sbus;
	logic                  footer_sbus2;
	logic                  start;
	logic [GROUP_W-1:0]    group_eff;
	logic                  burst_eff;
	logic [SLOT_CNT_W-1:0] cnt_eff;
	logic [TIMER_W-1:0]    timer_eff;
	logic [TIMER_W-1:0]    target;
	logic                  fire;
	logic [SLOT_IDX_W-1:0] idx;
	logic                  present;

	always_comb begin
		is_tick = 1'b0;
		is_byte = 1'b0;
		ram_wr  = '0;
		case (func)
			FUNC_RX_BYTE:  is_byte = accept;
			FUNC_TICK:     is_tick = accept;
			FUNC_VALUE_WR: begin
				ram_wr.en   = accept;
				ram_wr.addr = slot_index;
				ram_wr.data = sensor_value;
			end
			default: ;
		endcase
	end

	always_comb begin
		frame_open   = (byte_count_q != '0);
		idle_inc     = (idle_q != TIMER_MAX) ? idle_q + 1'b1 : idle_q;
		close        = frame_open && (idle_inc >= frame_gap_q);
		frame_ok     = (byte_count_q == FRAME_LEN) && header_ok_q;
		footer_sbus  = (footer_q == FOOTER_SBUS);
		footer_sbus2 = (footer_q[7:6] == 2'b00) && (footer_q[3:0] == FOOTER_SBUS2_LOW);
		start        = close && frame_ok && ((footer_sbus && !mute_q) || footer_sbus2);

		group_eff = group_q;
		if (close && frame_ok && footer_sbus && !mute_q) begin
			group_eff = group_q + 1'b1;
		end else if (close && frame_ok && footer_sbus2) begin
			group_eff = footer_q[4 +: GROUP_W];
		end

		// A burst start takes over the idle time already elapsed and skips the increment.
		burst_eff = start || burst_q;
		cnt_eff   = start ? '0 : slot_cnt_q;
		if (start) begin
			timer_eff = idle_inc;
		end else if (burst_q && slot_timer_q != TIMER_MAX) begin
			timer_eff = slot_timer_q + 1'b1;
		end else begin
			timer_eff = slot_timer_q;
		end

		if (cnt_eff == '0) begin
			target = zero_delay_q;
		end else if (inter_delay_q == '0) begin
			target = TIMER_W'(1);
		end else begin
			target = inter_delay_q;
		end

		fire    = burst_eff && (timer_eff >= target);
		idx     = {group_eff, cnt_eff};
		present = mask_q[idx];
	end

	assign ram_rd.en    = is_tick && fire && present;
	assign ram_rd.addr  = idx;
	assign job.fire     = is_tick && fire && present;
	assign job.slot_id  = SLOT_ID_TABLE[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_delay_q  <= TIMER_W'(2000);
			inter_delay_q <= TIMER_W'(660);
			frame_gap_q   <= TIMER_W'(500);
			mask_q        <= '0;
		end else if (cfg.en) begin
			case (sts_reg_t'(cfg.index))
				REG_SLOT_ZERO_DELAY:  zero_delay_q  <= cfg.data[TIMER_W-1:0];
				REG_INTER_SLOT_DELAY: inter_delay_q <= cfg.data[TIMER_W-1:0];
				REG_FRAME_GAP:        frame_gap_q   <= cfg.data[TIMER_W-1:0];
				REG_PRESENT_MASK:     mask_q        <= cfg.data[TOTAL_SLOTS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q      <= '0;
			mute_q       <= 1'b1;
			byte_count_q <= '0;
			header_ok_q  <= 1'b0;
			footer_q     <= '0;
			idle_q       <= '0;
			burst_q      <= 1'b0;
			slot_cnt_q   <= '0;
			slot_timer_q <= '0;
		end else if (is_byte) begin
			if (byte_count_q == '0) begin
				header_ok_q <= (rx_byte == HEADER_BYTE);
			end
			if (byte_count_q != BYTE_COUNT_MAX) begin
				byte_count_q <= byte_count_q + 1'b1;
			end
			footer_q <= rx_byte;
			idle_q   <= '0;
		end else if (is_tick) begin
			group_q <= group_eff;
			if (close && frame_ok && footer_sbus) begin
				mute_q <= !mute_q;
			end
			if (close) begin
				byte_count_q <= '0;
				header_ok_q  <= 1'b0;
				idle_q       <= '0;
			end else if (frame_open) begin
				idle_q <= idle_inc;
			end
			if (fire) begin
				slot_timer_q <= '0;
				if (cnt_eff == LAST_SLOT) begin
					slot_cnt_q <= '0;
					burst_q    <= 1'b0;
				end else begin
					slot_cnt_q <= cnt_eff + 1'b1;
					burst_q    <= 1'b1;
				end
			end else begin
				slot_timer_q <= timer_eff;
				slot_cnt_q   <= cnt_eff;
				burst_q      <= burst_eff;
			end
		end
	end

	`STS_ASSERT_NOW(a_idle_slot_zero, !burst_q, slot_cnt_q == '0, "slot counter set outside a burst")
	`STS_ASSERT_NOW(a_closed_no_idle, byte_count_q == '0, idle_q == '0, "idle count runs with no open frame")

endmodule

>>> design/sts_tx_emitter.sv
// Output stage: registers the job for the value read, then sends ID, low, high bytes.
// Depends on sts_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sts_tx_emitter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sts_pkg::sts_job_t                 job,
	input  logic [sts_pkg::VALUE_W-1:0]       rd_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        out_byte,
	output logic                              out_last,
	output sts_pkg::sts_emit_status_t         status
);
	import sts_pkg::*;

	sts_job_t          job_s1;
	logic              emit_valid_q;
	sts_byte_sel_t     sel_q;
	logic [7:0]        id_q;
	logic [VALUE_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_s1       <= '0;
			emit_valid_q <= 1'b0;
			sel_q        <= BYTE_ID;
		end else begin
			job_s1 <= job;
			if (job_s1.fire) begin
				emit_valid_q <= 1'b1;
				sel_q        <= BYTE_ID;
			end else if (emit_valid_q && out_ready) begin
				case (sel_q)
					BYTE_ID:   sel_q <= BYTE_LOW;
					BYTE_LOW:  sel_q <= BYTE_HIGH;
					BYTE_HIGH: emit_valid_q <= 1'b0;
					default:   emit_valid_q <= 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_s1.fire) begin
			id_q    <= job_s1.slot_id;
			value_q <= rd_data;
		end
	end

	always_comb begin
		case (sel_q)
			BYTE_ID:   out_byte = id_q;
			BYTE_LOW:  out_byte = value_q[7:0];
			BYTE_HIGH: out_byte = value_q[15:8];
			default:   out_byte = id_q;
		endcase
	end

	assign out_valid        = emit_valid_q;
	assign out_last         = (sel_q == BYTE_HIGH);
	assign status.job_wait  = job_s1.fire;
	assign status.byte_hold = emit_valid_q && !(out_ready && sel_q == BYTE_HIGH);

	`STS_ASSERT_NOW(a_no_overrun, job_s1.fire, !emit_valid_q, "slot job arrived while bytes still pending")
	`STS_ASSERT_NEXT(a_load_first, job_s1.fire, emit_valid_q && sel_q == BYTE_ID, "slot job not loaded")

endmodule

>>> tb/tb_sbus2_telemetry_slot_scheduler.sv
`timescale 1ns / 1ps
// Self-checking testbench for sbus2_telemetry_slot_scheduler: directed command streams
// with random payload, and a cycle-free mirror of the scheduler that predicts every byte.
// Depends on sts_pkg and the scheduler RTL.
module tb_sbus2_telemetry_slot_scheduler;
	import sts_pkg::*;

	// Command code that the block must ignore.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam int SETTLE_CYCLES  = 8;
	localparam int RESET_CYCLES   = 9;
	localparam int HOLD_CYCLES    = 300;
	localparam int RUN_LIMIT_NS   = 8_000_000;

	// Footers of a frame that may start a burst: plain bus, then the four group selects.
	localparam logic [7:0] BURST_FOOTERS [5] = '{
		FOOTER_SBUS,
		{4'd0, FOOTER_SBUS2_LOW},
		{4'd1, FOOTER_SBUS2_LOW},
		{4'd2, FOOTER_SBUS2_LOW},
		{4'd3, FOOTER_SBUS2_LOW}
	};

	typedef struct packed {
		logic [7:0] data;
		logic       tlast;
	} tx_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	sbus2_telemetry_slot_scheduler DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the scheduler registers, updated once per accepted command or register write.
	logic [15:0] zero_delay;
	logic [15:0] slot_spacing;
	logic [15:0] close_gap;
	logic [31:0] present_mask;
	logic [15:0] value_store [TOTAL_SLOTS];
	logic [1:0]  group_q;
	logic        mute_q;
	logic [4:0]  rx_count;
	logic        header_seen;
	logic [7:0]  last_rx;
	logic [15:0] idle_run;
	logic        burst_on;
	logic [2:0]  slot_pos;
	logic [15:0] slot_wait;

	// Telemetry bytes predicted but not yet seen on the master stream, oldest first.
	tx_beat_t telemetry_due [$];

	int n_mismatch = 0;
	// Random idling on both streams; cleared for the closing part of the run.
	bit idling = 1'b1;
	// Set by a test to make the receiver hold off for that many cycles.
	int hold_req = 0;
	int rx_hold_left = 0;

	task automatic report_mismatch(input string what);
		n_mismatch++;
		$display("ERROR at %0t ns: %s", $time, what);
	endtask

	// Works out the bytes that one accepted command causes. A tick first looks for the
	// end of the open frame and then advances the slot schedule, so a burst started by
	// the closing tick can fire slot 0 on that very tick.
	function automatic void predict_telemetry(input logic [31:0] word);
		logic [1:0]  fn;
		logic [7:0]  rx;
		logic [4:0]  slot;
		logic [15:0] val;
		logic [15:0] target;
		logic        started;
		tx_beat_t    beat;
		fn = word[1:0];
		rx = word[9:2];
		slot = word[14:10];
		val = word[30:15];
		started = 1'b0;
		case (fn)
			FUNC_RX_BYTE: begin
				if (rx_count == '0)
					header_seen = (rx == HEADER_BYTE);
				if (rx_count != BYTE_COUNT_MAX)
					rx_count = rx_count + 5'd1;
				last_rx = rx;
				idle_run = '0;
			end
			FUNC_VALUE_WR: begin
				value_store[slot] = val;
			end
			FUNC_TICK: begin
				if (rx_count != '0) begin
					if (idle_run != TIMER_MAX)
						idle_run = idle_run + 16'd1;
					if (idle_run >= close_gap) begin
						if (rx_count == FRAME_LEN && header_seen) begin
							if (last_rx == FOOTER_SBUS) begin
								// Plain frames only start a burst every second time.
								if (!mute_q) begin
									group_q = group_q + 2'd1;
									started = 1'b1;
								end
								mute_q = ~mute_q;
							end else if (last_rx[7:6] == 2'b00 &&
									last_rx[3:0] == FOOTER_SBUS2_LOW) begin
								group_q = last_rx[5:4];
								started = 1'b1;
							end
						end
						if (started) begin
							burst_on = 1'b1;
							slot_pos = '0;
							slot_wait = idle_run;
						end
						rx_count = '0;
						header_seen = 1'b0;
						idle_run = '0;
					end
				end
				if (burst_on) begin
					if (!started && slot_wait != TIMER_MAX)
						slot_wait = slot_wait + 16'd1;
					if (slot_pos == '0)
						target = zero_delay;
					else
						target = (slot_spacing == '0) ? 16'd1 : slot_spacing;
					if (slot_wait >= target) begin
						slot = {group_q, slot_pos};
						// An absent slot keeps its place in time but sends nothing.
						if (present_mask[slot]) begin
							val = value_store[slot];
							beat.data = SLOT_ID_TABLE[slot];
							beat.tlast = 1'b0;
							telemetry_due.push_back(beat);
							beat.data = val[7:0];
							telemetry_due.push_back(beat);
							beat.data = val[15:8];
							beat.tlast = 1'b1;
							telemetry_due.push_back(beat);
						end
						slot_wait = '0;
						if (slot_pos == LAST_SLOT) begin
							slot_pos = '0;
							burst_on = 1'b0;
						end else begin
							slot_pos = slot_pos + 3'd1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	// The command word keeps the code in its two low bits and the fields above it.
	function automatic logic [31:0] pack_cmd(input logic [1:0] fn, input logic [7:0] rx,
			input logic [4:0] slot, input logic [15:0] val);
		return {1'b0, val, slot, rx, fn};
	endfunction

	// Ticks that cover a whole burst from the last frame byte on.
	function automatic int full_burst_ticks();
		return int'(close_gap) + int'(zero_delay) +
			7 * ((slot_spacing == '0) ? 1 : int'(slot_spacing)) + 2;
	endfunction

	// Offers one command until it transfers, predicts it, and may then pause the sender.
	// The code goes out on tuser and the remaining fields on tdata.
	// The valid is only lowered by a pause or by wait_idle, never right before a raise.
	task automatic send_cmd(input logic [31:0] word);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= word[1:0];
		s_axis_tdata <= {3'b000, word[30:2]};
		do @(posedge clk); while (!s_axis_tready);
		predict_telemetry(word);
		if (idling && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_cmd(pack_cmd(FUNC_RX_BYTE, b, 5'($urandom), 16'($urandom)));
	endtask

	task automatic send_value(input logic [4:0] slot, input logic [15:0] val);
		send_cmd(pack_cmd(FUNC_VALUE_WR, 8'($urandom), slot, val));
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_cmd(pack_cmd(FUNC_TICK, 8'($urandom), 5'($urandom), 16'($urandom)));
	endtask

	// Sends a byte run; with mix set, value writes and ignored commands are slipped in
	// between bytes, which must not disturb the frame.
	task automatic send_frame(input logic [7:0] first, input int len, input logic [7:0] footer,
			input bit mix);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			if (i == 0)
				b = first;
			else if (i == len - 1)
				b = footer;
			else
				b = 8'($urandom);
			send_byte(b);
			if (mix && $urandom_range(0, 15) == 0) begin
				if ($urandom_range(0, 1) == 0)
					send_value(5'($urandom), 16'($urandom));
				else
					send_cmd(pack_cmd(FUNC_UNUSED, 8'($urandom), 5'($urandom),
						16'($urandom)));
			end
		end
	endtask

	// Stops the sender until every predicted byte has come out, then lets the block
	// settle, since the last commands may have been ticks that fire nothing.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (telemetry_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input sts_reg_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SLOT_ZERO_DELAY:  zero_delay = val[15:0];
			REG_INTER_SLOT_DELAY: slot_spacing = val[15:0];
			REG_FRAME_GAP:        close_gap = val[15:0];
			REG_PRESENT_MASK:     present_mask = val;
			default: begin
			end
		endcase
	endtask

	task automatic set_timing(input logic [15:0] first, input logic [15:0] spacing,
			input logic [15:0] gap, input logic [31:0] mask);
		wait_idle();
		write_reg(REG_SLOT_ZERO_DELAY, {16'd0, first});
		write_reg(REG_INTER_SLOT_DELAY, {16'd0, spacing});
		write_reg(REG_FRAME_GAP, {16'd0, gap});
		write_reg(REG_PRESENT_MASK, mask);
	endtask

	// Stored values at the extremes, plus a command with the unused code.
	task automatic test_value_writes();
		send_value(5'd0, 16'h0000);
		send_value(5'd31, 16'hFFFF);
		send_value(5'd9, 16'hA55A);
		send_value(5'd16, 16'h5AA5);
		send_value(5'd8, 16'h00FF);
		send_cmd(pack_cmd(FUNC_UNUSED, 8'hFF, 5'd31, 16'hFFFF));
	endtask

	// Plain frames: the first one only toggles the mute flag, the second one moves the
	// group on and starts a burst. The second frame has other commands slipped in.
	task automatic test_plain_frames();
		set_timing(16'd1, 16'd1, 16'd1, 32'hAAAA_5555);
		send_frame(HEADER_BYTE, FRAME_BYTES, FOOTER_SBUS, 1'b0);
		send_ticks(2);
		send_frame(HEADER_BYTE, FRAME_BYTES, FOOTER_SBUS, 1'b1);
		send_ticks(full_burst_ticks());
	endtask

	// A zero frame gap closes on the first tick, a zero spacing behaves as one tick, and a
	// first-slot delay no longer than the frame gap fires slot 0 on the closing tick.
	// The second frame restarts the burst halfway through, in another group.
	task automatic test_zero_delays();
		set_timing(16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);
		send_frame(HEADER_BYTE, FRAME_BYTES, BURST_FOOTERS[4], 1'b0);
		send_ticks(4);
		send_frame(HEADER_BYTE, FRAME_BYTES, BURST_FOOTERS[1], 1'b0);
		send_ticks(full_burst_ticks());
	endtask

	// Ticks with no frame open, and short runs with or without the header byte that
	// end in a group-select footer: no telemetry at all.
	task automatic test_rejected_frames();
		set_timing(16'd0, 16'd1, 16'd2, 32'hFFFF_FFFF);
		send_ticks(2);
		send_frame(HEADER_BYTE, 3, BURST_FOOTERS[2], 1'b0);
		send_ticks(3);
		send_frame(8'h0E, 2, BURST_FOOTERS[3], 1'b0);
		send_ticks(3);
	endtask

	// The receiver holds off for a long stretch while commands keep coming, so the block
	// fills up and drops s_axis_tready until the receiver takes bytes again. Idling stays
	// off from here to the end of the run.
	task automatic test_output_stall();
		set_timing(16'd2, 16'd1, 16'd1, 32'hFFFF_FFFF);
		idling = 1'b0;
		hold_req = HOLD_CYCLES;
		send_frame(HEADER_BYTE, FRAME_BYTES, BURST_FOOTERS[1], 1'b0);
		send_ticks(full_burst_ticks());
	endtask

	// Receiver side: random stall bursts, and the long hold-off when a test asks for it.
	always @(posedge clk) begin
		if (hold_req != 0) begin
			rx_hold_left = hold_req;
			hold_req = 0;
		end
		if (rx_hold_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold_left--;
		end else if (idling && $urandom_range(0, 7) == 0) begin
			m_axis_tready <= 1'b0;
			rx_hold_left = $urandom_range(0, 11);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Every byte transfer on the master stream is matched against the oldest prediction.
	always @(posedge clk) begin
		tx_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (telemetry_due.size() == 0) begin
				report_mismatch($sformatf("byte %02h tlast %0b with nothing expected",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = telemetry_due.pop_front();
				if (m_axis_tdata !== want.data || m_axis_tlast !== want.tlast)
					report_mismatch($sformatf("byte %02h tlast %0b, expected %02h tlast %0b",
						m_axis_tdata, m_axis_tlast, want.data, want.tlast));
			end
		end
	end

	initial begin
		zero_delay = 16'd2000;
		slot_spacing = 16'd660;
		close_gap = 16'd500;
		present_mask = '0;
		for (int s = 0; s < TOTAL_SLOTS; s++)
			value_store[s] = '0;
		group_q = '0;
		mute_q = 1'b1;
		rx_count = '0;
		header_seen = 1'b0;
		last_rx = '0;
		idle_run = '0;
		burst_on = 1'b0;
		slot_pos = '0;
		slot_wait = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_value_writes();
		test_plain_frames();
		test_zero_delays();
		test_rejected_frames();
		test_output_stall();
		wait_idle();
		if (n_mismatch == 0 && telemetry_due.size() == 0) begin
			$display("sbus2_telemetry_slot_scheduler: match");
		end else begin
			$display("sbus2_telemetry_slot_scheduler: mismatch");
		end
		$finish;
	end

	// Safety net: a hung handshake or a lost byte ends the run here.
	initial begin
		#(RUN_LIMIT_NS);
		$display("sbus2_telemetry_slot_scheduler: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/sts_pkg.sv
design/sts_value_ram.sv
design/sts_frame_sched.sv
design/sts_tx_emitter.sv
design/sbus2_telemetry_slot_scheduler.sv
tb/tb_sbus2_telemetry_slot_scheduler.sv
